/* hdl/rgbser_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the RGB LED pulse-width serializer.
package rgbser_pkg;

	localparam int COLOUR_W        = 24;
	localparam int HIGH_W          = 12;
	localparam int TICK_W          = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int WORD_BITS_DEF   = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_LATCH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST  = 3'd4;

	localparam logic [HIGH_W-1:0] ZERO_HIGH_RST  = 12'd20;
	localparam logic [HIGH_W-1:0] ONE_HIGH_RST   = 12'd40;
	localparam logic [HIGH_W-1:0] BIT_PERIOD_RST = 12'd63;
	localparam logic [TICK_W-1:0] LATCH_LOW_RST  = 16'd3000;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEND,
		PH_LATCH
	} phase_t;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_LOAD,
		CMD_LATCH,
		CMD_NONE
	} cmd_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [COLOUR_W-1:0] word;
	} q_entry_t;

	typedef struct packed {
		logic [HIGH_W-1:0] zero_high;
		logic [HIGH_W-1:0] one_high;
		logic [HIGH_W-1:0] bit_period;
		logic [TICK_W-1:0] latch_low;
		logic              msb_first;
	} cfg_t;

endpackage

/* hdl/rgbser_front.sv */
`timescale 1ns / 1ps
// Front stage: takes input items, decodes the opcode and pushes commands to the queue.
module rgbser_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic [rgbser_pkg::COLOUR_W-1:0]    colour_word,
	input  logic                               q_full,
	output logic                               q_push,
	output rgbser_pkg::q_entry_t               q_wdata
);
	import rgbser_pkg::*;

	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [COLOUR_W-1:0] word_s1;
	cmd_t                cmd_dec;
	logic                in_xfer;

	always_comb begin
		case (opcode)
			OP_TICK:  cmd_dec = CMD_TICK;
			OP_LOAD:  cmd_dec = CMD_LOAD;
			OP_LATCH: cmd_dec = CMD_LATCH;
			default:  cmd_dec = CMD_NONE;
		endcase
	end

	assign in_stall = valid_s1 && q_full;
	assign in_xfer  = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;
	assign q_wdata  = '{cmd: cmd_s1, word: word_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1  <= cmd_dec;
			word_s1 <= colour_word;
		end
	end

endmodule

/* hdl/rgbser_queue.sv */
`timescale 1ns / 1ps
// Small command queue between the front stage and the line sequencer.
module rgbser_queue #(
	parameter int DEPTH = rgbser_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rgbser_pkg::q_entry_t  wdata,
	output logic                  full,
	input  logic                  pop,
	output logic                  rd_valid,
	output rgbser_pkg::q_entry_t  rdata
);
	import rgbser_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_FULL);
	assign rd_valid = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* hdl/rgbser_back.sv */
`timescale 1ns / 1ps
// Line sequencer: runs bit and latch timing per command and registers the result.
module rgbser_back #(
	parameter int WORD_BITS = rgbser_pkg::WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rgbser_pkg::cfg_t      cfg,
	input  logic                  q_valid,
	input  rgbser_pkg::q_entry_t  q_rdata,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  line_level,
	output logic                  busy_res,
	output logic                  rejected,
	output logic                  finished
);
	import rgbser_pkg::*;

	localparam int BIDX_W = $clog2(WORD_BITS);
	localparam logic [BIDX_W-1:0] LAST_BIT = BIDX_W'(WORD_BITS - 1);

	phase_t                phase_q, phase_n;
	logic [TICK_W-1:0]     tick_q, tick_n, tick_inc;
	logic [BIDX_W-1:0]     bits_q, bits_n, bit_idx;
	logic [WORD_BITS-1:0]  word_q, word_n;
	logic [WORD_BITS+COLOUR_W-1:0] word_ext;
	logic [HIGH_W-1:0]     per_lim, high_ticks;
	logic [TICK_W-1:0]     latch_lim;
	logic                  busy;
	logic                  rej_n, fin_n, line_n;

	logic out_valid_q, line_q, busy_q, rej_q, fin_q;

	assign q_pop    = q_valid && (!out_valid_q || !out_stall);
	assign busy     = (phase_q != PH_IDLE);
	assign tick_inc = tick_q + 1'b1;
	assign per_lim  = (cfg.bit_period == '0) ? HIGH_W'(1) : cfg.bit_period;
	assign latch_lim = (cfg.latch_low == '0) ? TICK_W'(1) : cfg.latch_low;
	assign word_ext = {{WORD_BITS{1'b0}}, q_rdata.word};

	always_comb begin
		phase_n = phase_q;
		tick_n  = tick_q;
		bits_n  = bits_q;
		word_n  = word_q;
		rej_n   = 1'b0;
		fin_n   = 1'b0;
		case (q_rdata.cmd)
			CMD_LOAD: begin
				if (busy) begin
					rej_n = 1'b1;
				end else begin
					word_n  = word_ext[WORD_BITS-1:0];
					bits_n  = LAST_BIT;
					tick_n  = '0;
					phase_n = PH_SEND;
				end
			end
			CMD_LATCH: begin
				if (busy) begin
					rej_n = 1'b1;
				end else begin
					tick_n  = '0;
					phase_n = PH_LATCH;
				end
			end
			CMD_TICK: begin
				if (phase_q == PH_SEND) begin
					tick_n = tick_inc;
					if (tick_inc >= TICK_W'(per_lim)) begin
						tick_n = '0;
						if (bits_q == '0) begin
							phase_n = PH_IDLE;
							fin_n   = 1'b1;
						end else begin
							bits_n = bits_q - 1'b1;
						end
					end
				end else if (phase_q == PH_LATCH) begin
					tick_n = tick_inc;
					if (tick_inc >= latch_lim) begin
						tick_n  = '0;
						phase_n = PH_IDLE;
						fin_n   = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// line level seen after this command
	always_comb begin
		bit_idx    = cfg.msb_first ? bits_n : LAST_BIT - bits_n;
		high_ticks = word_n[bit_idx] ? cfg.one_high : cfg.zero_high;
		line_n     = (phase_n == PH_SEND) && (tick_n < TICK_W'(high_ticks));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bits_q  <= '0;
			word_q  <= '0;
		end else if (q_pop) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			bits_q  <= bits_n;
			word_q  <= word_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			line_q <= line_n;
			busy_q <= (phase_n != PH_IDLE);
			rej_q  <= rej_n;
			fin_q  <= fin_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_level = line_q;
	assign busy_res   = busy_q;
	assign rejected   = rej_q;
	assign finished   = fin_q;

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fin_q |-> !busy_q)
		else $error("finished reported while still busy");

	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rej_q |-> busy_q && !fin_q)
		else $error("rejected command without busy state");

	a_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && line_q |-> busy_q)
		else $error("line high while idle");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_rdata.cmd == CMD_LOAD && phase_q == PH_IDLE |=> phase_q == PH_SEND)
		else $error("load from idle did not start a word");

endmodule

/* hdl/rgb_led_pulse_width_serializer.sv */
`timescale 1ns / 1ps
// One-wire RGB LED encoder: serializes colour words as pulse-width coded bits on tick items.
// A result passes the front register at the input transfer, then the command queue,
// then the result register; a full queue or out_stall can hold it between them.
// Throughput: one item per clock while out_stall is low; the sequencer retires one command per cycle unless stalled.
// Reset (arst_n low, asynchronous): timing registers to defaults, sequencer idle, queue empty.
module rgb_led_pulse_width_serializer #(
	parameter int WORD_BITS   = rgbser_pkg::WORD_BITS_DEF,
	parameter int QUEUE_DEPTH = rgbser_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [rgbser_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rgbser_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic [rgbser_pkg::COLOUR_W-1:0]     colour_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                line_level,
	output logic                                busy_res,
	output logic                                rejected,
	output logic                                finished
);
	import rgbser_pkg::*;

	cfg_t     cfg_q;
	q_entry_t q_wdata;
	q_entry_t q_rdata;
	logic     q_push, q_full, q_pop, q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high  <= ZERO_HIGH_RST;
			cfg_q.one_high   <= ONE_HIGH_RST;
			cfg_q.bit_period <= BIT_PERIOD_RST;
			cfg_q.latch_low  <= LATCH_LOW_RST;
			cfg_q.msb_first  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ZERO_HIGH:  cfg_q.zero_high  <= cfg_data[HIGH_W-1:0];
				REG_ONE_HIGH:   cfg_q.one_high   <= cfg_data[HIGH_W-1:0];
				REG_BIT_PERIOD: cfg_q.bit_period <= cfg_data[HIGH_W-1:0];
				REG_LATCH_LOW:  cfg_q.latch_low  <= cfg_data[TICK_W-1:0];
				REG_MSB_FIRST:  cfg_q.msb_first  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rgbser_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.colour_word (colour_word),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_wdata     (q_wdata)
	);

	rgbser_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rdata    (q_rdata)
	);

	rgbser_back #(
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_level (line_level),
		.busy_res   (busy_res),
		.rejected   (rejected),
		.finished   (finished)
	);

endmodule

/* sim/tb_rgb_led_pulse_width_serializer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the RGB LED pulse-width serializer with its own line predictor.
module tb_rgb_led_pulse_width_serializer;
	import rgbser_pkg::*;

	localparam int WORD_BITS    = 24;
	localparam int LIMIT        = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_ITEMS  = 275;

	localparam logic [1:0]           OP_NONE         = CMD_NONE;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic line;
		logic busy;
		logic rej;
		logic fin;
	} led_result_t;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [1:0]            opcode      = OP_TICK;
	logic [COLOUR_W-1:0]   colour_word = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic                  line_level;
	logic                  busy_res;
	logic                  rejected;
	logic                  finished;

	// predictor state
	cfg_t                led_cfg;
	logic [COLOUR_W-1:0] enc_word;
	logic [4:0]          enc_bits_left;
	logic [TICK_W-1:0]   enc_ticks;
	phase_t              enc_phase;

	led_result_t line_results_q[$];
	led_result_t want_res;
	int          err_cnt    = 0;
	int          cycle_cnt  = 0;
	bit          send_idles = 1'b1;
	bit          recv_idles = 1'b1;

	rgb_led_pulse_width_serializer #(
		.WORD_BITS(WORD_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.colour_word(colour_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_level (line_level),
		.busy_res   (busy_res),
		.rejected   (rejected),
		.finished   (finished)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAIL");
		$finish;
	end

	function automatic led_result_t step_encoder(logic [1:0] op, logic [COLOUR_W-1:0] word);
		led_result_t       res;
		logic [TICK_W-1:0] lim;
		logic [4:0]        idx;
		logic [HIGH_W-1:0] hi;
		res = '0;
		if (op == OP_LOAD || op == OP_LATCH) begin
			if (enc_phase != PH_IDLE) begin
				res.rej = 1'b1;
			end else if (op == OP_LOAD) begin
				enc_word      = word;
				enc_bits_left = 5'(WORD_BITS - 1);
				enc_ticks     = '0;
				enc_phase     = PH_SEND;
			end else begin
				enc_ticks = '0;
				enc_phase = PH_LATCH;
			end
		end else if (op == OP_TICK) begin
			if (enc_phase == PH_SEND) begin
				enc_ticks = enc_ticks + 1'b1;
				lim = (led_cfg.bit_period == '0) ? 16'd1 : TICK_W'(led_cfg.bit_period);
				if (enc_ticks >= lim) begin
					enc_ticks = '0;
					if (enc_bits_left == '0) begin
						enc_phase = PH_IDLE;
						res.fin   = 1'b1;
					end else begin
						enc_bits_left = enc_bits_left - 1'b1;
					end
				end
			end else if (enc_phase == PH_LATCH) begin
				enc_ticks = enc_ticks + 1'b1;
				lim = (led_cfg.latch_low == '0) ? 16'd1 : led_cfg.latch_low;
				if (enc_ticks >= lim) begin
					enc_ticks = '0;
					enc_phase = PH_IDLE;
					res.fin   = 1'b1;
				end
			end
		end
		if (enc_phase == PH_SEND) begin
			idx = led_cfg.msb_first ? enc_bits_left : 5'(WORD_BITS - 1) - enc_bits_left;
			hi = enc_word[idx] ? led_cfg.one_high : led_cfg.zero_high;
			res.line = (enc_ticks < TICK_W'(hi));
		end
		res.busy = (enc_phase != PH_IDLE);
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (line_results_q.size() == 0) begin
				report_mismatch("result with no transfer pending", 1, 0);
			end else begin
				want_res = line_results_q.pop_front();
				if (line_level !== want_res.line)
					report_mismatch("line_level", line_level, want_res.line);
				if (busy_res !== want_res.busy)
					report_mismatch("busy_res", busy_res, want_res.busy);
				if (rejected !== want_res.rej)
					report_mismatch("rejected", rejected, want_res.rej);
				if (finished !== want_res.fin)
					report_mismatch("finished", finished, want_res.fin);
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= recv_idles && ($urandom_range(0, 99) < 34);
	end

	task automatic send_item(logic [1:0] op, logic [COLOUR_W-1:0] word);
		bit done;
		done = 1'b0;
		if (send_idles) begin
			while ($urandom_range(0, 99) < 34) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		colour_word <= word;
		while (!done) begin
			@(posedge clk);
			if (!in_stall) begin
				line_results_q.push_back(step_encoder(op, word));
				done = 1'b1;
			end
			@(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (line_results_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_ZERO_HIGH:  led_cfg.zero_high  = data[HIGH_W-1:0];
			REG_ONE_HIGH:   led_cfg.one_high   = data[HIGH_W-1:0];
			REG_BIT_PERIOD: led_cfg.bit_period = data[HIGH_W-1:0];
			REG_LATCH_LOW:  led_cfg.latch_low  = data[TICK_W-1:0];
			REG_MSB_FIRST:  led_cfg.msb_first  = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_idle_commands();
		send_item(OP_NONE, 24'hFFFFFF);
		send_item(OP_TICK, 24'h000000);
	endtask

	task automatic test_busy_rejects();
		send_item(OP_LOAD, 24'hFFFFFF);
		send_item(OP_NONE, 24'h000000);
		send_item(OP_LOAD, 24'h000000);
		send_item(OP_LATCH, 24'h5A5A5A);
		send_item(OP_TICK, 24'h000000);
	endtask

	// registers rewritten in the middle of a word
	task automatic test_live_timing();
		drain();
		write_reg(REG_BIT_PERIOD, 16'h0FFF);
		write_reg(REG_ZERO_HIGH, 16'h0FFF);
		write_reg(REG_ONE_HIGH, 16'h0FFF);
		send_item(OP_TICK, 24'h000000);
		drain();
		write_reg(REG_BIT_PERIOD, 16'hF000);
		write_reg(REG_ONE_HIGH, 16'h0000);
		send_item(OP_TICK, 24'h000000);
		send_item(OP_TICK, 24'h000000);
		drain();
		write_reg(REG_MSB_FIRST, 16'hFFFF);
		write_reg(REG_ONE_HIGH, 16'h0001);
		while (enc_phase != PH_IDLE)
			send_item(OP_TICK, 24'h000000);
	endtask

	task automatic test_latch_extremes();
		drain();
		write_reg(REG_LATCH_LOW, 16'hFFFF);
		write_reg(REG_UNMAPPED_LO, 16'hFFFF);
		write_reg(REG_UNMAPPED_HI, 16'hFFFF);
		send_item(OP_LATCH, 24'h000000);
		send_item(OP_TICK, 24'h000000);
		send_item(OP_TICK, 24'h000000);
		drain();
		write_reg(REG_LATCH_LOW, 16'h0000);
		send_item(OP_TICK, 24'h000000);
		send_item(OP_LOAD, 24'h000001);
	endtask

	task automatic pick_settings();
		logic [HIGH_W-1:0] zero_hi;
		logic [HIGH_W-1:0] one_hi;
		zero_hi = ($urandom_range(0, 99) < 10) ? 12'hFFF : 12'($urandom_range(0, 9));
		one_hi  = ($urandom_range(0, 99) < 10) ? 12'hFFF : 12'($urandom_range(0, 9));
		write_reg(REG_ZERO_HIGH, {4'($urandom), zero_hi});
		write_reg(REG_ONE_HIGH, {4'($urandom), one_hi});
		write_reg(REG_BIT_PERIOD, {4'($urandom), 12'($urandom_range(0, 7))});
		write_reg(REG_LATCH_LOW, 16'($urandom_range(0, 20)));
		write_reg(REG_MSB_FIRST, 16'($urandom));
		if ($urandom_range(0, 3) == 0)
			write_reg(3'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), 16'($urandom));
	endtask

	task automatic random_item();
		int                  r;
		logic [COLOUR_W-1:0] word;
		r = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0:       word = 24'h000000;
			1:       word = 24'hFFFFFF;
			default: word = 24'($urandom);
		endcase
		if (enc_phase == PH_IDLE) begin
			if (r < 55)
				send_item(OP_LOAD, word);
			else if (r < 80)
				send_item(OP_LATCH, word);
			else if (r < 90)
				send_item(OP_TICK, word);
			else
				send_item(OP_NONE, word);
		end else begin
			if (r < 88)
				send_item(OP_TICK, word);
			else if (r < 92)
				send_item(OP_LOAD, word);
			else if (r < 96)
				send_item(OP_LATCH, word);
			else
				send_item(OP_NONE, word);
		end
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			pick_settings();
			send_idles = (ph != 2);
			recv_idles = (ph != 2);
			repeat (PHASE_ITEMS) random_item();
		end
		send_idles = 1'b1;
		recv_idles = 1'b1;
	endtask

	initial begin
		led_cfg       = '{ZERO_HIGH_RST, ONE_HIGH_RST, BIT_PERIOD_RST, LATCH_LOW_RST, 1'b0};
		enc_word      = '0;
		enc_bits_left = '0;
		enc_ticks     = '0;
		enc_phase     = PH_IDLE;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_idle_commands();
		test_busy_rejects();
		test_live_timing();
		test_latch_extremes();
		test_random_traffic();
		drain();
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
hdl/rgbser_pkg.sv
hdl/rgbser_front.sv
hdl/rgbser_queue.sv
hdl/rgbser_back.sv
hdl/rgb_led_pulse_width_serializer.sv
sim/tb_rgb_led_pulse_width_serializer.sv
